// ===== sv/i2a_pkg.sv =====
// Shared types, character constants and digit encoding for the integer to ASCII converter.
package i2a_pkg;

  localparam int unsigned RADIX_W = 5;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_ALPHA  = 8'h57;  // 'a' - 10
  localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'h00;

  typedef struct packed {
    logic busy;
    logic done;
  } i2a_div_stat_t;

  typedef struct packed {
    logic empty;
    logic full;
  } i2a_lifo_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + d_ext;
    end else begin
      return CHAR_ALPHA + d_ext;
    end
  endfunction

endpackage

// ===== sv/i2a_div.sv =====
// Shared restoring divider: one quotient bit per cycle, divisor up to sixteen.
module i2a_div #(
  parameter int unsigned W = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [W-1:0]                  dividend,
  input  logic [i2a_pkg::RADIX_W-1:0]   divisor,
  output logic [W-1:0]                  quotient,
  output logic [i2a_pkg::DIGIT_W-1:0]   remainder,
  output i2a_pkg::i2a_div_stat_t        stat
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]                q_r;
  logic [i2a_pkg::DIGIT_W-1:0] rem_r;
  logic [CW-1:0]               cnt_r;
  logic                        done_r;

  logic [i2a_pkg::RADIX_W-1:0] shifted;
  logic [i2a_pkg::RADIX_W-1:0] diff;
  logic                        ge;

  // remainder stays below the divisor (<= 16), so it fits in four bits
  assign shifted = {rem_r, q_r[W-1]};
  assign diff    = shifted - divisor;
  assign ge      = (shifted >= divisor);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      q_r   <= {q_r[W-2:0], ge};
      rem_r <= ge ? diff[i2a_pkg::DIGIT_W-1:0] : shifted[i2a_pkg::DIGIT_W-1:0];
    end
  end

  assign quotient  = q_r;
  assign remainder = rem_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

// ===== sv/i2a_digit_lifo.sv =====
// Digit stack: remainders pushed least significant first, popped most significant first.
module i2a_digit_lifo #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [i2a_pkg::DIGIT_W-1:0]   push_data,
  input  logic                          pop,
  output logic [i2a_pkg::DIGIT_W-1:0]   rd_data,
  output i2a_pkg::i2a_lifo_stat_t       stat
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(DEPTH + 1);

  logic [i2a_pkg::DIGIT_W-1:0] mem [DEPTH];
  logic [i2a_pkg::DIGIT_W-1:0] rd_data_r;
  logic [PW-1:0]               sp_r;
  logic [PW-1:0]               sp_dec;

  assign sp_dec = sp_r - PW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (push) begin
      sp_r <= sp_r + PW'(1);
    end else if (pop) begin
      sp_r <= sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[sp_r[AW-1:0]] <= push_data;
    end
    if (pop) begin
      rd_data_r <= mem[sp_dec[AW-1:0]];
    end
  end

  assign rd_data    = rd_data_r;
  assign stat.empty = (sp_r == '0);
  assign stat.full  = (sp_r == PW'(DEPTH));

endmodule

// ===== sv/integer_to_ascii_radix.sv =====
// Top level: integer to ASCII digit string converter, bases 2 to 16.
//
//  channel  | ports                                         | direction
//  ---------+-----------------------------------------------+----------
//  in       | in_valid, in_ready, in_value, in_radix,       | request in
//           | in_treat_unsigned                             |
//  out      | out_valid, out_ready, out_character,          | request out
//           | out_last_char, out_bad_radix                  |
//
//  One request at a time; in_ready is high only between conversions.
//  Each digit takes a full pass of the shared one-bit-per-cycle divider
//  (S_DIV, S_WAIT); each character is then read from the stack (S_POP,
//  S_LOAD) and held in S_DIGIT until the out handshake completes.
//  A bad base gives one flagged result, registered in the cycle after acceptance.
//  Reset is synchronous, active low; no clearing pass. Out stalls hold the sequencer.
module integer_to_ascii_radix #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [63:0]            in_value,
  input  logic [4:0]                    in_radix,
  input  logic                          in_treat_unsigned,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_character,
  output logic                          out_last_char,
  output logic                          out_bad_radix
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIGN,
    S_DIV,
    S_WAIT,
    S_POP,
    S_LOAD,
    S_DIGIT
  } state_t;

  state_t                          state_r;
  logic [VALUE_BITS-1:0]           val_r;
  logic [i2a_pkg::RADIX_W-1:0]     radix_r;
  logic                            out_valid_r;
  logic [i2a_pkg::CHAR_W-1:0]      out_char_r;
  logic                            out_last_r;
  logic                            out_bad_r;

  logic [VALUE_BITS-1:0]           v_in;
  logic [VALUE_BITS-1:0]           v_neg;
  logic                            radix_bad;
  logic                            want_sign;
  logic                            in_acc;
  logic                            out_acc;

  logic                            div_start;
  logic [VALUE_BITS-1:0]           div_q;
  logic [i2a_pkg::DIGIT_W-1:0]     div_rem;
  i2a_pkg::i2a_div_stat_t          div_stat;

  logic                            lifo_push;
  logic                            lifo_pop;
  logic [i2a_pkg::DIGIT_W-1:0]     lifo_data;
  i2a_pkg::i2a_lifo_stat_t         lifo_stat;

  assign v_in      = in_value[VALUE_BITS-1:0];
  assign v_neg     = ~v_in + {{(VALUE_BITS-1){1'b0}}, 1'b1};
  assign radix_bad = (in_radix < i2a_pkg::RADIX_MIN) || (in_radix > i2a_pkg::RADIX_MAX);
  assign want_sign = !in_treat_unsigned && (in_radix == i2a_pkg::RADIX_DEC)
                     && v_in[VALUE_BITS-1];

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid_r && out_ready;

  assign div_start = (state_r == S_DIV);
  assign lifo_push = (state_r == S_WAIT) && div_stat.done;
  assign lifo_pop  = (state_r == S_POP);

  i2a_div #(
    .W (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (val_r),
    .divisor   (radix_r),
    .quotient  (div_q),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  i2a_digit_lifo #(
    .DEPTH (VALUE_BITS)
  ) u_lifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (lifo_push),
    .push_data (div_rem),
    .pop       (lifo_pop),
    .rd_data   (lifo_data),
    .stat      (lifo_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            radix_r <= in_radix;
            if (radix_bad) begin
              out_valid_r <= 1'b1;
              out_char_r  <= i2a_pkg::CHAR_NONE;
              out_last_r  <= 1'b1;
              out_bad_r   <= 1'b1;
              state_r     <= S_DIGIT;
            end else if (want_sign) begin
              val_r       <= v_neg;
              out_valid_r <= 1'b1;
              out_char_r  <= i2a_pkg::CHAR_MINUS;
              out_last_r  <= 1'b0;
              out_bad_r   <= 1'b0;
              state_r     <= S_SIGN;
            end else begin
              val_r   <= v_in;
              state_r <= S_DIV;
            end
          end
        end
        S_SIGN: begin
          if (out_acc) begin
            out_valid_r <= 1'b0;
            state_r     <= S_DIV;
          end
        end
        S_DIV: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (div_stat.done) begin
            val_r   <= div_q;
            // quotient of zero means the last digit has been produced
            state_r <= (div_q == '0) ? S_POP : S_DIV;
          end
        end
        S_POP: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          out_valid_r <= 1'b1;
          out_char_r  <= i2a_pkg::digit_char(lifo_data);
          out_last_r  <= lifo_stat.empty;
          out_bad_r   <= 1'b0;
          state_r     <= S_DIGIT;
        end
        S_DIGIT: begin
          if (out_acc) begin
            out_valid_r <= 1'b0;
            state_r     <= out_last_r ? S_IDLE : S_POP;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last_char = out_last_r;
  assign out_bad_radix = out_bad_r;

  // the converter never takes a request while a result is still pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request accepted while result pending");

  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_radix) |-> out_last_char)
    else $error("bad base result not marked last");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_WAIT))
    else $error("divider finished outside wait state");

  a_lifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(lifo_push && lifo_stat.full))
    else $error("digit stack overflow");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_char) |=> (in_ready && lifo_stat.empty))
    else $error("conversion ended with digits left");

endmodule

// ===== dv/i2a_string_check.sv =====
// Digit string predictor and result comparison for the integer to ASCII converter.
`timescale 1ns / 1ps
module i2a_string_check #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_value,
  input  logic [4:0]  in_radix,
  input  logic        in_treat_unsigned,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_character,
  input  logic        out_last_char,
  input  logic        out_bad_radix,
  output int          fail_count,
  output int          pending,
  output int          chars_checked
);

  typedef struct packed {
    logic [i2a_pkg::CHAR_W-1:0] ch;
    logic                       last;
    logic                       bad;
  } char_beat_t;

  localparam string DIGIT_SET = "0123456789abcdef";

  char_beat_t expected_chars[$];

  // Queue the characters that one request should produce.
  task automatic expand_conversion(input logic [63:0] raw,
                                   input logic [i2a_pkg::RADIX_W-1:0] radix,
                                   input logic uns);
    logic [63:0]                mask;
    logic [63:0]                v;
    logic [63:0]                base;
    logic [i2a_pkg::CHAR_W-1:0] digits [64];
    int                         nd;
    char_beat_t                 beat;
    mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
    v    = raw & mask;
    nd   = 0;
    if (radix < i2a_pkg::RADIX_MIN || radix > i2a_pkg::RADIX_MAX) begin
      beat.ch   = i2a_pkg::CHAR_NONE;
      beat.last = 1'b1;
      beat.bad  = 1'b1;
      expected_chars.push_back(beat);
      return;
    end
    beat.bad = 1'b0;
    if (!uns && radix == i2a_pkg::RADIX_DEC && v[VALUE_BITS-1]) begin
      beat.ch   = i2a_pkg::CHAR_MINUS;
      beat.last = 1'b0;
      expected_chars.push_back(beat);
      v = (~v + 64'd1) & mask;
    end
    base = 64'(radix);
    do begin
      digits[nd] = DIGIT_SET[int'(v % base)];
      nd++;
      v = v / base;
    end while (v != 0);
    while (nd > 0) begin
      nd--;
      beat.ch   = digits[nd];
      beat.last = (nd == 0);
      expected_chars.push_back(beat);
    end
  endtask

  always @(posedge clk) begin
    char_beat_t beat;
    if (!rst_n) begin
      expected_chars.delete();
      fail_count    = 0;
      chars_checked = 0;
    end else begin
      if (in_valid && in_ready) begin
        expand_conversion(in_value, in_radix, in_treat_unsigned);
      end
      if (out_valid && out_ready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result char %h last %b bad %b", $time,
                   out_character, out_last_char, out_bad_radix);
        end else begin
          beat = expected_chars.pop_front();
          if (beat.ch !== out_character || beat.last !== out_last_char ||
              beat.bad !== out_bad_radix) begin
            fail_count++;
            $display("%0t: mismatch expected char %h last %b bad %b, got char %h last %b bad %b",
                     $time, beat.ch, beat.last, beat.bad,
                     out_character, out_last_char, out_bad_radix);
          end
        end
      end
    end
    pending = expected_chars.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the integer to ASCII converter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned VALUE_BITS = 64;
  localparam int RANDOM_REQS = 156;
  localparam int QUIET_TAIL  = 30;
  localparam int STALL_LIMIT = 20000;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [63:0]                   in_value;
  logic [i2a_pkg::RADIX_W-1:0]   in_radix;
  logic                          in_treat_unsigned;
  logic                          out_valid;
  logic                          out_ready;
  logic [i2a_pkg::CHAR_W-1:0]    out_character;
  logic                          out_last_char;
  logic                          out_bad_radix;

  logic in_acc      = 1'b0;
  bit   quiet       = 1'b0;
  int   out_hold    = 0;
  int   idle_cycles = 0;
  int   reqs_sent   = 0;
  int   bad_sent    = 0;
  int   fail_count;
  int   pending;
  int   chars_checked;

  integer_to_ascii_radix #(.VALUE_BITS(VALUE_BITS)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_value          (in_value),
    .in_radix          (in_radix),
    .in_treat_unsigned (in_treat_unsigned),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_character     (out_character),
    .out_last_char     (out_last_char),
    .out_bad_radix     (out_bad_radix)
  );

  i2a_string_check #(.VALUE_BITS(VALUE_BITS)) string_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_value          (in_value),
    .in_radix          (in_radix),
    .in_treat_unsigned (in_treat_unsigned),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_character     (out_character),
    .out_last_char     (out_last_char),
    .out_bad_radix     (out_bad_radix),
    .fail_count        (fail_count),
    .pending           (pending),
    .chars_checked     (chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // request acceptance, read by the sender at the following falling edge
  always @(posedge clk) begin
    in_acc <= in_valid && in_ready;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL integer_to_ascii_radix");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // random receiver back-pressure in bursts
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_ready <= 1'b1;
    end else if (out_hold != 0) begin
      out_ready <= 1'b0;
      out_hold  <= out_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      out_hold  <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(input logic [63:0] value,
                              input logic [i2a_pkg::RADIX_W-1:0] radix,
                              input logic uns);
    in_valid          <= 1'b1;
    in_value          <= value;
    in_radix          <= radix;
    in_treat_unsigned <= uns;
    do @(negedge clk); while (!in_acc);
    reqs_sent++;
    if (radix < i2a_pkg::RADIX_MIN || radix > i2a_pkg::RADIX_MAX) bad_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] pick_value(input logic [i2a_pkg::RADIX_W-1:0] radix);
    logic [63:0] p;
    p = 64'd1;
    case ($urandom_range(0, 5))
      0, 1: return {$urandom, $urandom};
      2: return 64'($urandom_range(0, 200));
      3: return -64'($urandom_range(1, 200));
      4: begin
        // around a power of the base, where the digit count changes
        if (radix >= i2a_pkg::RADIX_MIN && radix <= i2a_pkg::RADIX_MAX) begin
          repeat ($urandom_range(1, 20)) p = p * 64'(radix);
        end
        return p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return 64'd0;
          1: return 64'h7fff_ffff_ffff_ffff;
          2: return 64'h8000_0000_0000_0000;
          3: return '1;
          default: return 64'd1 << $urandom_range(0, 63);
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [i2a_pkg::RADIX_W-1:0] r;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_value          = '0;
    in_radix          = '0;
    in_treat_unsigned = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(64'd0, i2a_pkg::RADIX_DEC, 1'b0);
    send_request(64'd0, i2a_pkg::RADIX_MIN, 1'b1);
    send_request(64'h7fff_ffff_ffff_ffff, i2a_pkg::RADIX_DEC, 1'b0);
    send_request(64'h8000_0000_0000_0000, i2a_pkg::RADIX_DEC, 1'b0);  // most negative, signed
    send_request(64'h8000_0000_0000_0000, i2a_pkg::RADIX_DEC, 1'b1);
    send_request('1, i2a_pkg::RADIX_DEC, 1'b0);
    send_request('1, i2a_pkg::RADIX_DEC, 1'b1);
    send_request('1, i2a_pkg::RADIX_MAX, 1'b0);                       // no sign outside base ten
    send_request('1, i2a_pkg::RADIX_MIN, 1'b0);                       // longest string
    send_request(64'd1234, 5'd0, 1'b0);
    send_request(64'd1234, 5'd1, 1'b1);
    send_request(64'd1234, 5'd17, 1'b0);
    send_request('1, 5'd31, 1'b1);
    for (int b = 3; b < 16; b++) begin
      if (b != 10) send_request({$urandom, $urandom}, 5'(b), 1'($urandom_range(0, 1)));
    end
    drain_wait();

    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i == RANDOM_REQS / 2) drain_wait();
      if (i == RANDOM_REQS - QUIET_TAIL) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0) r = 5'($urandom_range(0, 31));
      else r = 5'($urandom_range(2, 16));
      send_request(pick_value(r), r, 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("Ran %0d conversions (%0d with a base out of range), %0d characters compared.",
             reqs_sent, bad_sent, chars_checked);
    $display("Bases 0 to 31, signed and unsigned, zero, extremes and digit-count edges.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS integer_to_ascii_radix");
    end else begin
      $display("FAIL integer_to_ascii_radix");
    end
    $finish;
  end

endmodule
